// ===== sv/cme_pkg.sv =====
// Package for the cycle mapping enumerator: constants, codes and state types.
// No dependencies.
`default_nettype none
package cme_pkg;
  localparam int unsigned MAX_CYCLES_DEF = 16;

  typedef enum logic [1:0] {
    ACT_NEW  = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_ADV  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_GROUP_LENGTH = 2'd0,
    REG_GRAPH_MODE   = 2'd1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_DIR,
    ST_DIG,
    ST_PFIND_I,
    ST_PFIND_J,
    ST_PSWAP,
    ST_PREV,
    ST_PMAP,
    ST_PRESET,
    ST_EMIT_MUL,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/cme_if.sv =====
// Valid/ready stream interfaces for the enumerator's input and result words.
// Depends on nothing.
`default_nettype none
interface cme_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] cycle_length;
  logic [7:0] cycle_start;
  modport source (output valid, action, cycle_length, cycle_start, input ready);
  modport sink (input valid, action, cycle_length, cycle_start, output ready);
endinterface

interface cme_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cycle_position;
  logic [7:0] start_offset;
  logic       direction;
  logic [7:0] start_value;
  logic       more;
  logic       last;
  modport source (output valid, cycle_position, start_offset, direction, start_value,
                  more, last, input ready);
  modport sink (input valid, cycle_position, start_offset, direction, start_value,
                more, last, output ready);
endinterface
`default_nettype wire

// ===== sv/cme_div.sv =====
// Restoring divider, one quotient bit per cycle, for the length reduction.
// Depends on nothing.
`default_nettype none
module cme_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      quotient
);
  logic [7:0] q_r, q_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic [8:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[7:0], q_r[7]};
    done     = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[6:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[6:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd7) busy_nxt = 1'b0;
    end else if (cnt_r == 4'd8) begin
      done    = 1'b1;
      cnt_nxt = 4'd0;
    end
  end

  assign quotient = q_r;

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/cycle_mapping_enumerator_core.sv =====
// Top level of the cycle mapping enumerator: sequencer, cycle tables, odometer.
// Depends on cme_pkg, cme_if and cme_div.
//
// channel | dir | words
// in_     | in  | action, cycle_length, cycle_start
// out_    | out | one word per loaded cycle on advance
// cfg_    | in  | group_length (0), graph_mode (1)
//
// A load runs through ST_DIV, waiting on the bit-serial divider, then ST_LOAD.
// An advance runs on one sequencer walking the tables one entry per cycle while
// no result word stalls; each result word passes ST_EMIT_MUL, then ST_EMIT.
// Reset clears counts, direction bits, digits and identity order at once.
// A stalled result word holds the sequencer; no input is taken until done.
`default_nettype none
module cycle_mapping_enumerator_core #(
  parameter int unsigned MAX_CYCLES = cme_pkg::MAX_CYCLES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  cme_in_if.sink          in_ch,
  cme_out_if.source       out_ch
);
  localparam int unsigned IW = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;
  localparam int unsigned CW = $clog2(MAX_CYCLES + 1);

  cme_pkg::state_t state_r, state_nxt;

  logic [7:0] glen_r;
  logic       gmode_r;
  logic [7:0] red_r [MAX_CYCLES];
  logic [7:0] sin_r [MAX_CYCLES];
  logic [7:0] sout_r [MAX_CYCLES];
  logic [IW-1:0] perm_r [MAX_CYCLES];
  logic       dir_r [MAX_CYCLES];
  logic [7:0] dig_r [MAX_CYCLES];
  logic [CW-1:0] rsz_r [MAX_CYCLES];
  logic [CW-1:0] rcnt_r, ncnt_r;
  logic [7:0] lraw_r;
  logic [7:0] len_r, st_r;
  logic [CW-1:0] i_r, j_r, base_r, r_r, sz_r, pi_r;
  logic       more_r, gv_r;
  logic [15:0] prod_r;

  logic [7:0] gl_eff;
  logic       div_start, div_done;
  logic [7:0] quo;

  assign gl_eff = (glen_r == 8'd0) ? 8'd1 : glen_r;

  cme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_ch.cycle_length),
    .divisor(gl_eff), .done(div_done), .quotient(quo)
  );

  logic acc;
  assign in_ch.ready = (state_r == cme_pkg::ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign div_start = acc && (in_ch.action == cme_pkg::ACT_NEW
                             || in_ch.action == cme_pkg::ACT_ADD);

  // combinational sequencer; table writes done in the clocked block by state
  logic [CW-1:0] n_eff;
  logic [CW:0]   szc;
  logic [CW-1:0] rem_n;
  logic [IW-1:0] ii, jj;
  always_comb begin
    rem_n = ncnt_r - base_r;
    szc = {1'b0, rsz_r[r_r[IW-1:0]]};
    if (szc > {1'b0, rem_n}) szc = {1'b0, rem_n};
    n_eff = ncnt_r;
    ii = i_r[IW-1:0];
    jj = j_r[IW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cme_pkg::ST_IDLE:
        if (acc) begin
          case (cme_pkg::action_t'(in_ch.action))
            cme_pkg::ACT_NEW, cme_pkg::ACT_ADD: state_nxt = cme_pkg::ST_DIV;
            cme_pkg::ACT_ADV: if (ncnt_r != '0) state_nxt = cme_pkg::ST_DIR;
            default: state_nxt = cme_pkg::ST_IDLE;
          endcase
        end
      cme_pkg::ST_DIV: if (div_done) state_nxt = cme_pkg::ST_LOAD;
      cme_pkg::ST_LOAD: state_nxt = cme_pkg::ST_IDLE;
      cme_pkg::ST_DIR: begin
        if (gmode_r) state_nxt = gv_r ? cme_pkg::ST_DIG : cme_pkg::ST_EMIT_MUL;
        else if (i_r == '0) state_nxt = cme_pkg::ST_DIG;
        else if (!dir_r[IW'(i_r - 1'b1)]) state_nxt = cme_pkg::ST_EMIT_MUL;
      end
      cme_pkg::ST_DIG:
        if (i_r == n_eff) state_nxt = cme_pkg::ST_PRESET;
        else if (dig_r[ii] + 8'd1 < red_r[ii]) state_nxt = cme_pkg::ST_EMIT_MUL;
      cme_pkg::ST_PRESET:
        if (r_r == rcnt_r || base_r >= ncnt_r) state_nxt = cme_pkg::ST_EMIT_MUL;
        else if (szc < 2) state_nxt = cme_pkg::ST_PMAP;
        else state_nxt = cme_pkg::ST_PFIND_I;
      cme_pkg::ST_PFIND_I:
        if (i_r == base_r) begin
          if (perm_r[ii] < perm_r[IW'(i_r + 1'b1)]) state_nxt = cme_pkg::ST_PFIND_J;
          else state_nxt = cme_pkg::ST_PMAP;
        end else if (perm_r[ii] < perm_r[IW'(i_r + 1'b1)]) state_nxt = cme_pkg::ST_PFIND_J;
      cme_pkg::ST_PFIND_J:
        if (j_r == i_r + 1'b1 || perm_r[jj] > perm_r[ii]) state_nxt = cme_pkg::ST_PSWAP;
      cme_pkg::ST_PSWAP: state_nxt = cme_pkg::ST_PREV;
      cme_pkg::ST_PREV: if (i_r >= j_r) state_nxt = cme_pkg::ST_PMAP;
      cme_pkg::ST_PMAP:
        if (pi_r == sz_r) state_nxt = more_r ? cme_pkg::ST_EMIT_MUL : cme_pkg::ST_PRESET;
      cme_pkg::ST_EMIT_MUL: state_nxt = cme_pkg::ST_EMIT;
      cme_pkg::ST_EMIT:
        if (out_ch.ready) state_nxt = (i_r == n_eff - 1'b1) ? cme_pkg::ST_IDLE
                                                             : cme_pkg::ST_EMIT_MUL;
      default: state_nxt = cme_pkg::ST_IDLE;
    endcase
  end

  assign out_ch.valid = (state_r == cme_pkg::ST_EMIT);
  assign out_ch.cycle_position = 4'(i_r);
  assign out_ch.start_offset = prod_r[7:0];
  assign out_ch.direction = dir_r[ii];
  assign out_ch.start_value = sout_r[ii];
  assign out_ch.more = more_r;
  assign out_ch.last = (i_r == n_eff - 1'b1);

  logic [IW-1:0] kk, src;
  logic [CW:0] modv;
  assign kk = ncnt_r[IW-1:0];
  always_comb begin
    modv = {1'b0, (CW)'(perm_r[IW'(base_r + pi_r)])};
    if (modv >= {1'b0, sz_r}) modv = modv - {1'b0, sz_r};
    src = IW'(base_r + modv[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cme_pkg::ST_IDLE;
      glen_r  <= 8'd1;
      gmode_r <= 1'b0;
      rcnt_r  <= '0;
      ncnt_r  <= '0;
      lraw_r  <= '0;
      for (int k = 0; k < MAX_CYCLES; k++) begin
        perm_r[k] <= IW'(k);
        dir_r[k]  <= 1'b0;
        dig_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == 1'(cme_pkg::REG_GROUP_LENGTH)) glen_r <= cfg_data;
        else gmode_r <= cfg_data[0];
      end
      case (state_r)
        cme_pkg::ST_IDLE:
          if (acc) begin
            len_r <= in_ch.cycle_length;
            st_r  <= in_ch.cycle_start;
            more_r <= 1'b1;
            i_r   <= ncnt_r;
            gv_r  <= dir_r[0];
            if (in_ch.action == cme_pkg::ACT_NEW) begin
              ncnt_r <= '0;
              rcnt_r <= '0;
            end
          end
        cme_pkg::ST_LOAD:
          if (ncnt_r < CW'(MAX_CYCLES)) begin
            red_r[kk]  <= (quo == 8'd0) ? 8'd1 : quo;
            sin_r[kk]  <= st_r;
            sout_r[kk] <= st_r;
            dir_r[kk]  <= 1'b0;
            dig_r[kk]  <= '0;
            if (ncnt_r != '0 && rcnt_r != '0 && len_r == lraw_r) begin
              perm_r[kk] <= IW'(rsz_r[IW'(rcnt_r - 1'b1)]);
              rsz_r[IW'(rcnt_r - 1'b1)] <= rsz_r[IW'(rcnt_r - 1'b1)] + 1'b1;
            end else if (rcnt_r < CW'(MAX_CYCLES)) begin
              perm_r[kk] <= '0;
              rsz_r[rcnt_r[IW-1:0]] <= CW'(1);
              rcnt_r <= rcnt_r + 1'b1;
            end
            lraw_r <= len_r;
            ncnt_r <= ncnt_r + 1'b1;
          end
        cme_pkg::ST_DIR:
          if (gmode_r) begin
            for (int k = 0; k < MAX_CYCLES; k++)
              if (CW'(k) < ncnt_r) dir_r[k] <= ~gv_r;
            i_r <= '0;
          end else if (i_r == '0) begin
            i_r <= '0;
          end else if (dir_r[IW'(i_r - 1'b1)]) begin
            dir_r[IW'(i_r - 1'b1)] <= 1'b0;
            i_r <= i_r - 1'b1;
          end else begin
            dir_r[IW'(i_r - 1'b1)] <= 1'b1;
            i_r <= '0;
          end
        cme_pkg::ST_DIG:
          if (i_r == n_eff) begin
            base_r <= '0;
            r_r    <= '0;
          end else if (dig_r[ii] + 8'd1 < red_r[ii]) begin
            dig_r[ii] <= dig_r[ii] + 8'd1;
            i_r <= '0;
          end else begin
            dig_r[ii] <= '0;
            i_r <= i_r + 1'b1;
          end
        cme_pkg::ST_PRESET:
          if (r_r == rcnt_r || base_r >= ncnt_r) begin
            more_r <= 1'b0;
            i_r <= '0;
          end else begin
            sz_r <= szc[CW-1:0];
            i_r  <= base_r + szc[CW-1:0] - 2'd2;
            pi_r <= '0;
            more_r <= 1'b0;
          end
        cme_pkg::ST_PFIND_I:
          if (perm_r[ii] < perm_r[IW'(i_r + 1'b1)]) j_r <= base_r + sz_r - 1'b1;
          else if (i_r != base_r) i_r <= i_r - 1'b1;
          else begin
            for (int k = 0; k < MAX_CYCLES; k++)
              if (CW'(k) >= base_r && CW'(k) < base_r + sz_r)
                perm_r[k] <= IW'(CW'(k) - base_r);
          end
        cme_pkg::ST_PFIND_J:
          if (!(j_r == i_r + 1'b1 || perm_r[jj] > perm_r[ii])) j_r <= j_r - 1'b1;
        cme_pkg::ST_PSWAP: begin
          perm_r[ii] <= perm_r[jj];
          perm_r[jj] <= perm_r[ii];
          i_r <= i_r + 1'b1;
          j_r <= base_r + sz_r - 1'b1;
          more_r <= 1'b1;
        end
        cme_pkg::ST_PREV:
          if (i_r < j_r) begin
            perm_r[ii] <= perm_r[jj];
            perm_r[jj] <= perm_r[ii];
            i_r <= i_r + 1'b1;
            j_r <= j_r - 1'b1;
          end
        cme_pkg::ST_PMAP:
          if (pi_r == sz_r) begin
            i_r <= '0;
            base_r <= base_r + sz_r;
            r_r <= r_r + 1'b1;
          end else begin
            sout_r[IW'(base_r + pi_r)] <= more_r ? sin_r[src] : sin_r[IW'(base_r + pi_r)];
            pi_r <= pi_r + 1'b1;
          end
        cme_pkg::ST_EMIT_MUL: prod_r <= dig_r[ii] * gl_eff;
        cme_pkg::ST_EMIT: if (out_ch.ready && !(i_r == n_eff - 1'b1)) i_r <= i_r + 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("result word while input open");
  assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r <= CW'(MAX_CYCLES))
    else $error("cycle count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.cycle_position))
    else $error("stalled word moved");
  assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= ncnt_r)
    else $error("more groups than cycles");
endmodule
`default_nettype wire

// ===== bench/cme_bench_if.sv =====
// Stream interfaces reused by the bench: the RTL's cme_in_if and cme_out_if are used as they are.
// This file holds a small helper package of bench constants; depends on cme_pkg.
package cme_bench_pkg;
  localparam int unsigned TABLE_DEPTH = cme_pkg::MAX_CYCLES_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
endpackage

// ===== bench/mapping_checker.sv =====
// Cycle mapping enumerator checker: watches both word channels, predicts result words from
// its own software odometer, compares field by field. Uses cme_pkg, cme_bench_pkg, cme_if.
module mapping_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  cme_in_if          in_ch,
  cme_out_if         out_ch,
  output int         fail_count,
  output int         pending_words,
  output int         words_seen,
  output int         wrap_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_MAX = cme_bench_pkg::TABLE_DEPTH;

  typedef bit bool;

  typedef struct packed {
    logic [3:0] position;
    logic [7:0] offset;
    logic       dir;
    logic [7:0] value;
    logic       more;
    logic       last;
  } map_word_t;

  logic [7:0] grp_len;
  logic       graph_on;
  logic [7:0] radix [N_MAX];
  logic [7:0] start_orig [N_MAX];
  logic [7:0] start_perm [N_MAX];
  logic [3:0] order [N_MAX];
  logic       dirs [N_MAX];
  logic [7:0] digits [N_MAX];
  logic [4:0] run_len [N_MAX];
  int         runs;
  int         loaded;
  logic [7:0] prev_len;
  map_word_t  expected_words [$];

  function automatic bool next_order(int base, int len);
    int i, j;
    logic [3:0] t;
    if (len < 2) return 0;
    i = len - 2;
    while (i >= 0 && order[base+i] > order[base+i+1]) i--;
    if (i < 0) return 0;
    j = len - 1;
    while (j > i + 1 && order[base+j] <= order[base+i]) j--;
    t = order[base+i]; order[base+i] = order[base+j]; order[base+j] = t;
    i++;
    j = len - 1;
    while (i < j) begin
      t = order[base+i]; order[base+i] = order[base+j]; order[base+j] = t;
      i++;
      j--;
    end
    return 1;
  endfunction

  task automatic add_cycle(logic [7:0] len, logic [7:0] st);
    int k, g, red;
    k = loaded;
    g = (grp_len == 0) ? 1 : grp_len;
    if (k >= N_MAX) return;
    red = len / g;
    if (red == 0) red = 1;
    radix[k] = 8'(red);
    start_orig[k] = st;
    start_perm[k] = st;
    dirs[k] = 0;
    digits[k] = 0;
    if (k > 0 && runs > 0 && len == prev_len) begin
      order[k] = 4'(run_len[runs-1]);
      run_len[runs-1]++;
    end else if (runs < N_MAX) begin
      order[k] = 0;
      run_len[runs] = 1;
      runs++;
    end
    prev_len = len;
    loaded = k + 1;
  endtask

  function automatic bool step_odometer();
    int i, r, base, sz, j;
    logic v;
    if (!graph_on) begin
      i = loaded;
      while (i > 0 && dirs[i-1]) begin
        i--;
        dirs[i] = 0;
      end
      if (i > 0) begin
        dirs[i-1] = 1;
        return 1;
      end
    end else begin
      v = dirs[0];
      for (i = 0; i < loaded; i++) dirs[i] = ~v;
      if (!v) return 1;
    end
    for (i = 0; i < loaded; i++) begin
      digits[i]++;
      if (digits[i] < radix[i]) return 1;
      digits[i] = 0;
    end
    base = 0;
    for (r = 0; r < runs && base < loaded; r++) begin
      sz = run_len[r];
      if (sz > loaded - base) sz = loaded - base;
      if (next_order(base, sz)) begin
        for (j = 0; j < sz; j++) start_perm[base+j] = start_orig[base + (order[base+j] % sz)];
        return 1;
      end
      for (j = 0; j < sz; j++) begin
        order[base+j] = 4'(j);
        start_perm[base+j] = start_orig[base+j];
      end
      base += sz;
    end
    return 0;
  endfunction

  task automatic predict_word(cme_pkg::action_t act, logic [7:0] len, logic [7:0] st);
    bool more_flag;
    map_word_t w;
    int k, g;
    case (act)
      cme_pkg::ACT_NEW: begin
        loaded = 0;
        runs = 0;
        add_cycle(len, st);
      end
      cme_pkg::ACT_ADD: add_cycle(len, st);
      cme_pkg::ACT_ADV: begin
        if (loaded != 0) begin
          more_flag = step_odometer();
          if (!more_flag) wrap_seen++;
          g = (grp_len == 0) ? 1 : grp_len;
          for (k = 0; k < loaded; k++) begin
            w.position = 4'(k);
            w.offset = 8'(digits[k] * g);
            w.dir = dirs[k];
            w.value = start_perm[k];
            w.more = more_flag;
            w.last = (k == loaded - 1);
            expected_words.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  map_word_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      grp_len = 1;
      graph_on = 0;
      runs = 0;
      loaded = 0;
      prev_len = 0;
      for (int i = 0; i < N_MAX; i++) begin
        order[i] = 4'(i);
        dirs[i] = 0;
        digits[i] = 0;
      end
      expected_words.delete();
      fail_count = 0;
      words_seen = 0;
      wrap_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(cme_pkg::REG_GROUP_LENGTH)) grp_len = cfg_data;
        else graph_on = cfg_data[0];
      end
      if (in_ch.valid && in_ch.ready)
        predict_word(cme_pkg::action_t'(in_ch.action), in_ch.cycle_length,
                     in_ch.cycle_start);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cycle_position, out_ch.start_offset, out_ch.direction,
                out_ch.start_value, out_ch.more, out_ch.last};
        words_seen++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected pos %0d off %0d dir %0d val %0d more %0d last %0d",
                       want.position, want.offset, want.dir, want.value, want.more,
                       want.last);
              $display("          got      pos %0d off %0d dir %0d val %0d more %0d last %0d",
                       got.position, got.offset, got.dir, got.value, got.more, got.last);
            end
          end
        end
      end
    end
    pending_words = expected_words.size();
  end
endmodule

// ===== bench/testbench.sv =====
// Top of the bench: drives loads, advances and register writes into the enumerator core and
// gives the verdict. Uses cme_pkg, cme_bench_pkg, cme_if, mapping_checker and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic [0:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;
  int         fail_count, pending_words, words_seen, wrap_seen;
  int         idle_cycles = 0;
  int         item_total = 0;
  bit         calm = 0;

  cme_in_if  in_ch ();
  cme_out_if out_ch ();

  cycle_mapping_enumerator_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  mapping_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_words(pending_words),
    .words_seen(words_seen), .wrap_seen(wrap_seen)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.action = cme_pkg::ACT_NONE;
    in_ch.cycle_length = 0;
    in_ch.cycle_start = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > cme_bench_pkg::STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(cme_pkg::action_t act, logic [7:0] len, logic [7:0] st);
    while (!calm && $urandom_range(99) < 10) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.cycle_length <= len;
    in_ch.cycle_start <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 0;
    item_total++;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cme_pkg::reg_index_t idx, logic [7:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx[0:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_list(int max_n, int max_len);
    int n;
    logic [7:0] len;
    n = $urandom_range(max_n, 1);
    len = 8'($urandom_range(max_len));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) len = 8'($urandom_range(max_len));
      send_word(i == 0 ? cme_pkg::ACT_NEW : cme_pkg::ACT_ADD, len, 8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed part
    send_word(cme_pkg::ACT_ADV, 8'd0, 8'd0);
    send_word(cme_pkg::ACT_NONE, 8'hff, 8'hff);
    send_word(cme_pkg::ACT_NEW, 8'd2, 8'h00);
    send_word(cme_pkg::ACT_ADD, 8'd2, 8'hff);
    send_word(cme_pkg::ACT_ADD, 8'd255, 8'h5a);
    repeat (10) send_word(cme_pkg::ACT_ADV, 8'd0, 8'd0);
    write_reg(cme_pkg::REG_GROUP_LENGTH, 8'd0);
    write_reg(cme_pkg::REG_GRAPH_MODE, 8'd1);
    send_word(cme_pkg::ACT_NEW, 8'd1, 8'ha5);
    for (int i = 1; i < 17; i++) send_word(cme_pkg::ACT_ADD, 8'd1, 8'(i));
    repeat (4) send_word(cme_pkg::ACT_ADV, 8'd0, 8'd0);
    write_reg(cme_pkg::REG_GROUP_LENGTH, 8'd255);
    send_word(cme_pkg::ACT_ADV, 8'd0, 8'd0);
    write_reg(cme_pkg::REG_GROUP_LENGTH, 8'd1);
    write_reg(cme_pkg::REG_GRAPH_MODE, 8'd0);
    // random part: mostly short lists of small lengths so permutations wrap
    while (item_total < 380) begin
      calm = (item_total > 200 && item_total < 260);
      if ($urandom_range(5) == 0) begin
        write_reg(cme_pkg::REG_GROUP_LENGTH,
                  $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(2, 1)));
        write_reg(cme_pkg::REG_GRAPH_MODE, 8'($urandom_range(1)));
      end
      random_list(($urandom_range(7) == 0) ? 17 : 4, ($urandom_range(4) == 0) ? 255 : 3);
      repeat ($urandom_range(12, 1)) begin
        if ($urandom_range(19) == 0)
          send_word(cme_pkg::action_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
        else
          send_word(cme_pkg::ACT_ADV, 8'($urandom), 8'($urandom));
      end
    end
    drain();
    $display("Covered %0d input words and %0d result words, %0d full wraps of the odometer.",
             item_total, words_seen, wrap_seen);
    if (fail_count == 0 && pending_words == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
